// ===== design/taylor_sine_cosine_top_assert.svh =====
// assertion macros for the checker module tsc_checker
`ifndef TAYLOR_SINE_COSINE_TOP_ASSERT_SVH
`define TAYLOR_SINE_COSINE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsc check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsc check failed");

`endif

// ===== design/tsc_pkg.sv =====
package tsc_pkg;

	// port field widths
	localparam int ANGLE_W = 32;
	localparam int VALUE_W = 32;

	// command codes
	localparam logic CMD_SINE   = 1'b0;
	localparam logic CMD_COSINE = 1'b1;

	// series length
	localparam int SERIES_TERMS_DEF = 3;
	localparam int MAX_TERMS        = 8;

	// range reduction in unsigned q48, biased so it never goes negative
	localparam int FRAC_IN   = 24;
	localparam int R_W       = 57;
	localparam int RED_STEPS = 6;
	localparam logic [R_W-1:0] PI_Q48      = 57'h3243F6A8885A3;
	localparam logic [R_W-1:0] TWO_PI_Q48  = 57'h6487ED5110B46;
	localparam logic [R_W-1:0] HALF_PI_Q48 = 57'h1921FB54442D2;
	localparam logic [R_W-1:0] WRAP_BIAS   = TWO_PI_Q48 << (RED_STEPS - 1);
	localparam logic [R_W-1:0] COS_BIAS    = HALF_PI_Q48 + WRAP_BIAS;

	// series datapath widths
	localparam int X_SHIFT     = 18;
	localparam int X_W         = 32;
	localparam int T_W         = 34;
	localparam int P_W         = 36;
	localparam int SUM_W       = 36;
	localparam int Q_FRAC      = 30;
	localparam int RECIP_W     = 34;
	localparam int RECIP_SHIFT = 36;
	localparam int DIV_W       = 9;

	// one item as it moves down the series pipeline
	typedef struct packed {
		logic                    vld;
		logic                    neg;
		logic [X_W-1:0]          x;
		logic [T_W-1:0]          t;
		logic signed [SUM_W-1:0] sum;
	} term_t;

	// divisor (e-1)*e of term k, e = 3 + 2k
	function automatic logic [DIV_W-1:0] term_div(input int unsigned k);
		logic [DIV_W-1:0] d;
		case (k)
			0: d = 9'd6;
			1: d = 9'd20;
			2: d = 9'd42;
			3: d = 9'd72;
			4: d = 9'd110;
			5: d = 9'd156;
			6: d = 9'd210;
			7: d = 9'd272;
			default: d = 9'd6;
		endcase
		return d;
	endfunction

	// floor(2^36 / divisor) of term k
	function automatic logic [RECIP_W-1:0] term_recip(input int unsigned k);
		logic [RECIP_W-1:0] m;
		case (k)
			0: m = 34'd11453246122;
			1: m = 34'd3435973836;
			2: m = 34'd1636178017;
			3: m = 34'd954437176;
			4: m = 34'd624722515;
			5: m = 34'd440509466;
			6: m = 34'd327235603;
			7: m = 34'd252645135;
			default: m = 34'd11453246122;
		endcase
		return m;
	endfunction

endpackage

// ===== design/tsc_reduce.sv =====
module tsc_reduce (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_vld,
	input  logic                         in_cmd,
	input  logic [tsc_pkg::ANGLE_W-1:0]  in_angle,
	output tsc_pkg::term_t               out_term
);
	import tsc_pkg::*;

	logic signed [R_W:0]  arg_ext;
	logic signed [R_W:0]  arg_sum;
	logic [R_W-1:0]       arg_s1;
	logic [R_W-1:0]       rem_chain [RED_STEPS+1];
	logic [RED_STEPS:0]   vld_s;
	logic                 fold;
	logic [R_W-1:0]       rem_fold;
	logic                 vld_s8;
	logic                 neg_s8;
	logic [X_W-1:0]       x_s8;

	// angle to q48, cosine as sine of pi/2 - angle, plus a whole number of turns
	always_comb begin
		arg_ext = {{(R_W + 1 - ANGLE_W - FRAC_IN){in_angle[ANGLE_W-1]}}, in_angle,
			{FRAC_IN{1'b0}}};
		if (in_cmd == CMD_COSINE) begin
			arg_sum = $signed({1'b0, COS_BIAS}) - arg_ext;
		end else begin
			arg_sum = arg_ext + $signed({1'b0, WRAP_BIAS});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1 <= arg_sum[R_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RED_STEPS-1:0], in_vld};
		end
	end

	assign rem_chain[0] = arg_s1;

	// restoring reduction, largest multiple of 2*pi first
	for (genvar j = 0; j < RED_STEPS; j++) begin : g_step
		localparam logic [R_W-1:0] STEP = TWO_PI_Q48 << (RED_STEPS - 1 - j);
		logic [R_W:0]   diff;
		logic [R_W-1:0] rem_s;

		assign diff = {1'b0, rem_chain[j]} - {1'b0, STEP};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s <= diff[R_W] ? rem_chain[j] : diff[R_W-1:0];
			end
		end

		assign rem_chain[j+1] = rem_s;
	end

	// fold the upper half turn, pi itself stays
	assign fold     = rem_chain[RED_STEPS] > PI_Q48;
	assign rem_fold = fold ? rem_chain[RED_STEPS] - PI_Q48 : rem_chain[RED_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s8 <= fold;
			x_s8   <= rem_fold[X_SHIFT+X_W-1:X_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s[RED_STEPS];
		end
	end

	always_comb begin
		out_term.vld = vld_s8;
		out_term.neg = neg_s8;
		out_term.x   = x_s8;
		out_term.t   = {{(T_W - X_W){1'b0}}, x_s8};
		out_term.sum = $signed({{(SUM_W - X_W){1'b0}}, x_s8});
	end

endmodule

// ===== design/tsc_term.sv =====
module tsc_term #(
	parameter int unsigned K = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  tsc_pkg::term_t in_term,
	output tsc_pkg::term_t out_term
);
	import tsc_pkg::*;

	localparam logic [DIV_W-1:0]   DIV      = term_div(K);
	localparam logic [RECIP_W-1:0] RECIP    = term_recip(K);
	localparam logic               SUBTRACT = ((K % 2) == 0);

	logic [T_W+X_W-1:0]     prod1;
	logic [P_W+X_W-1:0]     prod2;
	logic [P_W+RECIP_W-1:0] prod3;
	logic [T_W+DIV_W-1:0]   back;
	logic [P_W-1:0]         rem;
	logic [T_W-1:0]         t_fix;

	logic [4:0]              vld_s;
	logic [P_W-1:0]          p1_s1;
	logic [P_W-1:0]          n_s2, n_s3;
	logic [T_W-1:0]          q_s3;
	logic [T_W-1:0]          t_s4, t_s5;
	logic [X_W-1:0]          x_s1, x_s2, x_s3, x_s4, x_s5;
	logic                    neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [SUM_W-1:0] sum_s1, sum_s2, sum_s3, sum_s4, sum_s5;

	// previous term times x twice, then divide by (e-1)*e through the reciprocal
	assign prod1 = (T_W+X_W)'(in_term.t) * (T_W+X_W)'(in_term.x);
	assign prod2 = (P_W+X_W)'(p1_s1) * (P_W+X_W)'(x_s1);
	assign prod3 = (P_W+RECIP_W)'(n_s2) * (P_W+RECIP_W)'(RECIP);
	assign back  = (T_W+DIV_W)'(q_s3) * (T_W+DIV_W)'(DIV);
	assign rem   = n_s3 - back[P_W-1:0];
	// estimate is low by at most one
	assign t_fix = (rem >= P_W'(DIV)) ? q_s3 + T_W'(1) : q_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= prod1[Q_FRAC+P_W-1:Q_FRAC];
			x_s1   <= in_term.x;
			neg_s1 <= in_term.neg;
			sum_s1 <= in_term.sum;

			n_s2   <= prod2[Q_FRAC+P_W-1:Q_FRAC];
			x_s2   <= x_s1;
			neg_s2 <= neg_s1;
			sum_s2 <= sum_s1;

			q_s3   <= prod3[RECIP_SHIFT+T_W-1:RECIP_SHIFT];
			n_s3   <= n_s2;
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;
			sum_s3 <= sum_s2;

			t_s4   <= t_fix;
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;
			sum_s4 <= sum_s3;

			t_s5   <= t_s4;
			x_s5   <= x_s4;
			neg_s5 <= neg_s4;
			if (SUBTRACT) begin
				sum_s5 <= sum_s4 - $signed({{(SUM_W - T_W){1'b0}}, t_s4});
			end else begin
				sum_s5 <= sum_s4 + $signed({{(SUM_W - T_W){1'b0}}, t_s4});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_term.vld};
		end
	end

	always_comb begin
		out_term.vld = vld_s[4];
		out_term.neg = neg_s5;
		out_term.x   = x_s5;
		out_term.t   = t_s5;
		out_term.sum = sum_s5;
	end

endmodule

// ===== design/tsc_out.sv =====
module tsc_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsc_pkg::term_t              in_term,
	output logic                        en,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tsc_pkg::VALUE_W-1:0] m_tdata
);
	import tsc_pkg::*;

	localparam int SAT_W = SUM_W + 1;
	localparam logic signed [SAT_W-1:0] VMAX =
		{{(SAT_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
	localparam logic signed [SAT_W-1:0] VMIN =
		{{(SAT_W - VALUE_W + 1){1'b1}}, {(VALUE_W - 1){1'b0}}};

	logic signed [SAT_W-1:0] sum_ext;
	logic signed [SAT_W-1:0] signed_sum;
	logic [VALUE_W-1:0]      sat_val;
	logic                    take;
	logic                    incoming;

	logic                    out_vld_q;
	logic [VALUE_W-1:0]      out_data_q;
	logic                    skid_vld_q;
	logic [VALUE_W-1:0]      skid_data_q;

	// apply sign, clamp to q2.30
	always_comb begin
		sum_ext    = {in_term.sum[SUM_W-1], in_term.sum};
		signed_sum = in_term.neg ? -sum_ext : sum_ext;
		if (signed_sum > VMAX) begin
			sat_val = VMAX[VALUE_W-1:0];
		end else if (signed_sum < VMIN) begin
			sat_val = VMIN[VALUE_W-1:0];
		end else begin
			sat_val = signed_sum[VALUE_W-1:0];
		end
	end

	assign en       = !skid_vld_q;
	assign take     = out_vld_q && m_tready;
	assign incoming = en && in_term.vld;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || take) begin
			out_vld_q <= incoming;
		end else if (incoming) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_vld_q || take) begin
			out_data_q <= sat_val;
		end else begin
			skid_data_q <= sat_val;
		end
	end

endmodule

// ===== design/taylor_sine_cosine_top.sv =====
// a transfer accepted on s_tdata passes the front end, one term unit per series term and the
// output register before it shows on m_tdata
// throughput: one transfer per cycle in both directions while m_tready stays high
// reset: arst_n low clears every valid bit and the output buffer at once; data regs keep junk
module taylor_sine_cosine_top #(
	parameter int SERIES_TERMS = tsc_pkg::SERIES_TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tsc_pkg::ANGLE_W-1:0] s_tdata,   // [31:0] angle, signed q8.24 radians
	input  logic                        s_tuser,   // [0] command, 0 sine 1 cosine
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tsc_pkg::VALUE_W-1:0] m_tdata    // [31:0] value, signed q2.30
);
	import tsc_pkg::*;

	// pipeline advance: the whole datapath moves together and only holds
	// while the output skid slot is occupied, so s_tready is a flop output
	logic  en;
	term_t link [SERIES_TERMS+1];

	assign s_tready = en;

	// front end: q48 conversion and cosine offset (1 stage), six restoring
	// subtract stages that strip multiples of 2*pi, then the half-turn fold
	// and cut to the q.30 argument x (1 stage)
	tsc_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.in_cmd   (s_tuser),
		.in_angle (s_tdata),
		.out_term (link[0])
	);

	// one five-stage unit per series term: two q.30 multiplies by x, a
	// reciprocal multiply for the factorial ratio, a one-step fix of the
	// quotient, then the alternating add or subtract into the running sum
	for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
		tsc_term #(
			.K (k)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_term  (link[k]),
			.out_term (link[k+1])
		);
	end

	// sign, saturation and the output register with its skid slot; while a
	// finished result waits here, the skid slot catches one more before the pipeline holds
	tsc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_term  (link[SERIES_TERMS]),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== design/tsc_checker.sv =====
`include "taylor_sine_cosine_top_assert.svh"

module tsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [tsc_pkg::VALUE_W-1:0] m_tdata
);

	// a stalled result holds
	`TSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// input side only backs up once a result sits untaken
	`TSC_ASSERT_NOW(a_stall_cause, $fell(s_tready), $past(m_tvalid && !m_tready))

	// with the skid slot full the output register is occupied
	`TSC_ASSERT_NOW(a_stall_has_out, !s_tready, m_tvalid)

	// taking the output frees the skid slot in the next cycle
	`TSC_ASSERT_NEXT(a_stall_release, !s_tready && m_tvalid && m_tready, s_tready && m_tvalid)

endmodule

bind taylor_sine_cosine_top tsc_checker u_tsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
